[rtl/gbc_pkg.sv]
// Shared types, S-box constants and the round function of the 28147-89 cipher pipeline.
// No dependencies; every other file of the block imports this package.
package gbc_pkg;

    localparam int NUM_ROUNDS  = 32;
    localparam int NUM_KEYS    = 8;
    localparam int KEY_IDX_W   = 3;
    localparam int HALF_W      = 32;
    localparam int BLOCK_W     = 64;
    localparam int ROUND_ROT   = 11;
    localparam int ROT_BACK    = 21;

    // Operation codes carried by the cmd field
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [NUM_KEYS-1:0][HALF_W-1:0] key_set_t;

    // Payload that travels with one block through the round stages
    typedef struct packed {
        logic              cmd;
        logic [HALF_W-1:0] n1;
        logic [HALF_W-1:0] n2;
    } stage_t;

    // Eight fixed 4-bit substitution boxes, box i serves nibble i
    localparam logic [3:0] SBOX [8][16] = '{
        '{4'h9, 4'h6, 4'h3, 4'h2, 4'h8, 4'hB, 4'h1, 4'h7,
          4'hA, 4'h4, 4'hE, 4'hF, 4'hC, 4'h0, 4'hD, 4'h5},
        '{4'h3, 4'h7, 4'hE, 4'h9, 4'h8, 4'hA, 4'hF, 4'h0,
          4'h5, 4'h2, 4'h6, 4'hC, 4'hB, 4'h4, 4'hD, 4'h1},
        '{4'hE, 4'h4, 4'h6, 4'h2, 4'hB, 4'h3, 4'hD, 4'h8,
          4'hC, 4'hF, 4'h5, 4'hA, 4'h0, 4'h7, 4'h1, 4'h9},
        '{4'hE, 4'h7, 4'hA, 4'hC, 4'hD, 4'h1, 4'h3, 4'h9,
          4'h0, 4'h2, 4'hB, 4'h4, 4'hF, 4'h8, 4'h5, 4'h6},
        '{4'hB, 4'h5, 4'h1, 4'h9, 4'h8, 4'hD, 4'hF, 4'h0,
          4'hE, 4'h4, 4'h2, 4'h3, 4'hC, 4'h7, 4'hA, 4'h6},
        '{4'h3, 4'hA, 4'hD, 4'hC, 4'h1, 4'h2, 4'h0, 4'hB,
          4'h7, 4'h5, 4'h9, 4'h4, 4'h8, 4'hF, 4'hE, 4'h6},
        '{4'h1, 4'hD, 4'h2, 4'h9, 4'h7, 4'hA, 4'h6, 4'h0,
          4'h8, 4'hC, 4'h4, 4'h5, 4'hF, 4'h3, 4'hB, 4'hE},
        '{4'hB, 4'hA, 4'hF, 4'h5, 4'h0, 4'hC, 4'hE, 4'h8,
          4'h6, 4'h2, 4'h3, 4'h9, 4'h1, 4'h7, 4'hD, 4'h4}
    };

    // Round function: add key mod 2^32, substitute nibbles, rotate left
    function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] half,
                                                  input logic [HALF_W-1:0] k);
        logic [HALF_W-1:0] x;
        logic [HALF_W-1:0] s;
        x = half + k;
        for (int i = 0; i < 8; i++) begin
            s[4*i +: 4] = SBOX[i][x[4*i +: 4]];
        end
        return {s[HALF_W-ROUND_ROT-1:0], s[HALF_W-1:ROT_BACK]};
    endfunction

endpackage

[rtl/gbc_keys.sv]
// Key register file: eight 32-bit round key words written through the config port.
// Depends on gbc_pkg for the key set type.
module gbc_keys
    import gbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [KEY_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]    cfg_data,
    output key_set_t             keys
);

    key_set_t key_reg;
    key_set_t key_next;

    // Replace the addressed key word on a write
    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            key_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign keys = key_reg;

endmodule

[rtl/gbc_round.sv]
// One pipeline stage: a single Feistel round followed by the stage register.
// Depends on gbc_pkg for the stage payload type and the round function.
module gbc_round
    import gbc_pkg::*;
#(
    parameter logic [KEY_IDX_W-1:0] ENC_IDX = '0,
    parameter logic [KEY_IDX_W-1:0] DEC_IDX = '0,
    parameter bit                   LAST    = 1'b0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  key_set_t keys,
    input  logic     valid_in,
    input  stage_t   data_in,
    output logic     valid_out,
    output stage_t   data_out
);

    logic              valid_reg;
    stage_t            data_reg;
    stage_t            data_next;
    logic [HALF_W-1:0] key;
    logic [HALF_W-1:0] t;

    // Pick the key word for this round by direction
    assign key = (data_in.cmd == CMD_DECRYPT) ? keys[DEC_IDX] : keys[ENC_IDX];
    assign t   = round_f(data_in.n1, key) ^ data_in.n2;

    // Swap halves except in the final round
    always_comb
    begin
        data_next.cmd = data_in.cmd;
        if (LAST)
        begin
            data_next.n1 = data_in.n1;
            data_next.n2 = t;
        end
        else
        begin
            data_next.n1 = t;
            data_next.n2 = data_in.n1;
        end
    end

    // Advance valid with the data; hold both while frozen
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

[rtl/gbc_out.sv]
// Output register with a one-entry skid stage that decouples the result side.
// Depends on gbc_pkg for the block width.
module gbc_out
    import gbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               last_valid,
    input  logic [BLOCK_W-1:0] last_block,
    output logic               adv,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [BLOCK_W-1:0] block_out
);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BLOCK_W-1:0] out_data_reg;
    logic [BLOCK_W-1:0] out_data_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    logic [BLOCK_W-1:0] skid_data_reg;
    logic [BLOCK_W-1:0] skid_data_next;
    logic               arrive;

    // Pipeline moves only while the skid stage is empty
    assign adv    = !skid_valid_reg;
    assign arrive = adv && last_valid;

    // Refill the output register, or park the arriving block in the skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = arrive;
                out_data_next  = last_block;
            end
        end
        else if (arrive)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = last_block;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign block_out = out_data_reg;

`ifndef SYNTH
    // Skid stage holds data only behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    // An empty output register never leads to a parked block
    a_no_skid_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |=> !skid_valid_reg)
        else $error("skid stage filled while output was free");

    // A parked block moves out as soon as the output is taken
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid stage failed to drain");
`endif

endmodule

[rtl/gost_block_cipher_ecb.sv]
// Top level of the 28147-89 ECB cipher: key registers, 32 round stages and output buffer.
// Depends on gbc_pkg, gbc_keys, gbc_round and gbc_out.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------
//  input   | in_valid / in_stall  | cmd, block_in
//  output  | out_valid / out_stall| block_out
//  config  | cfg_we               | cfg_index, cfg_data
//
// One block enters per cycle while in_stall is low; each of the 32 round stages does one
// round. The first round register loads at the transfer edge, then the block passes 31
// more round registers and the output register before it shows on the output.
// in_stall comes straight from the skid stage register: when a result is held on
// the output and a second one arrives, it parks in the skid and the rounds freeze.
// Reset clears all valid bits and the key words to zero.
module gost_block_cipher_ecb
    import gbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [KEY_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [BLOCK_W-1:0]   block_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BLOCK_W-1:0]   block_out
);

    key_set_t           keys;
    logic               adv;
    logic [NUM_ROUNDS:0] stage_valid;
    stage_t             stage_data [NUM_ROUNDS+1];
    logic [BLOCK_W-1:0] last_block;

    gbc_keys u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (keys)
    );

    // Feed the first round straight from the input port
    assign stage_valid[0]    = in_valid;
    assign stage_data[0].cmd = cmd;
    assign stage_data[0].n1  = block_in[HALF_W-1:0];
    assign stage_data[0].n2  = block_in[BLOCK_W-1:HALF_W];

    // Round chain: encryption keys 0..7 three times then 7..0, decryption the reverse
    for (genvar r = 0; r < NUM_ROUNDS; r++)
    begin : g_round
        localparam int POS = r % NUM_KEYS;
        localparam int ENC = (r < 3*NUM_KEYS) ? POS : (NUM_KEYS-1-POS);
        localparam int DEC = (r < NUM_KEYS) ? POS : (NUM_KEYS-1-POS);

        gbc_round #(
            .ENC_IDX (ENC[KEY_IDX_W-1:0]),
            .DEC_IDX (DEC[KEY_IDX_W-1:0]),
            .LAST    (r == NUM_ROUNDS-1)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .keys      (keys),
            .valid_in  (stage_valid[r]),
            .data_in   (stage_data[r]),
            .valid_out (stage_valid[r+1]),
            .data_out  (stage_data[r+1])
        );
    end

    assign last_block = {stage_data[NUM_ROUNDS].n2, stage_data[NUM_ROUNDS].n1};

    gbc_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .last_valid (stage_valid[NUM_ROUNDS]),
        .last_block (last_block),
        .adv        (adv),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .block_out  (block_out)
    );

    // Hold off new transfers while the round chain is frozen
    assign in_stall = !adv;

`ifndef SYNTH
    // A frozen chain keeps every valid bit where it was
    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(stage_valid[NUM_ROUNDS:1]))
        else $error("round chain moved while frozen");

    // An accepted block lands in the first round stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> stage_valid[1])
        else $error("accepted block missing from first stage");

    // A moving chain shifts its valid bits by one stage
    a_chain_shifts: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (stage_valid[NUM_ROUNDS:2] == $past(stage_valid[NUM_ROUNDS-1:1])))
        else $error("valid bits lost or repeated in round chain");
`endif

endmodule
